### rtl/frame_ring_status_manager_core_defines.svh
// Assertion macros for the frame ring status manager RTL.
`ifndef FRAME_RING_STATUS_MANAGER_CORE_DEFINES_SVH
`define FRAME_RING_STATUS_MANAGER_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define FRSM_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define FRSM_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/frsm_pkg.sv
// Types, codes and helper functions for the frame ring status manager.
`timescale 1ns / 1ps

package frsm_pkg;

    localparam int MAX_FRAMES = 8;
    localparam int FRAME_W    = 3;
    localparam int COUNT_W    = 4;
    localparam int STATUS_W   = 2;
    localparam int REQ_W      = 2;
    localparam int CODE_W     = 2;

    localparam logic [COUNT_W-1:0] FRAME_COUNT_RESET = 4'd3;
    localparam logic [COUNT_W-1:0] MAX_FRAMES_C      = 4'd8;

    // Per-frame status codes.
    localparam logic [STATUS_W-1:0] FS_FREE  = 2'd0;
    localparam logic [STATUS_W-1:0] FS_READY = 2'd1;
    localparam logic [STATUS_W-1:0] FS_INUSE = 2'd2;

    // Request types.
    localparam logic [REQ_W-1:0] REQ_PRODUCE = 2'd0;
    localparam logic [REQ_W-1:0] REQ_GET     = 2'd1;
    localparam logic [REQ_W-1:0] REQ_PUT     = 2'd2;

    // Result status codes.
    localparam logic [CODE_W-1:0] CODE_OK       = 2'd0;
    localparam logic [CODE_W-1:0] CODE_NO_FREE  = 2'd1;
    localparam logic [CODE_W-1:0] CODE_NO_READY = 2'd2;
    localparam logic [CODE_W-1:0] CODE_BAD_PUT  = 2'd3;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_CHECK
    } t_state;

    typedef struct packed {
        logic                en;
        logic [FRAME_W-1:0]  addr;
        logic [STATUS_W-1:0] data;
    } t_tbl_wr;

    // Ring size: zero counts as one frame, large counts saturate.
    function automatic logic [COUNT_W-1:0] ring_size(input logic [COUNT_W-1:0] cnt);
        logic [COUNT_W-1:0] n;
        n = cnt;
        if (cnt == '0) begin
            n = 4'd1;
        end else if (cnt > MAX_FRAMES_C) begin
            n = MAX_FRAMES_C;
        end
        return n;
    endfunction

    // Circular successor of a frame index within a ring of n frames.
    function automatic logic [COUNT_W-1:0] ring_next(input logic [COUNT_W-1:0] i,
                                                     input logic [COUNT_W-1:0] n);
        logic [COUNT_W-1:0] s;
        s = i + 4'd1;
        return (s >= n) ? '0 : s;
    endfunction

endpackage

### rtl/frsm_status_table.sv
// Status table: one two-bit status per frame, one read port and one write port.
`timescale 1ns / 1ps

module frsm_status_table (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic [frsm_pkg::FRAME_W-1:0]    i_rd_addr,
    output logic [frsm_pkg::STATUS_W-1:0]   o_rd_data,
    input  frsm_pkg::t_tbl_wr               i_wr
);

    logic [frsm_pkg::STATUS_W-1:0] r_status [frsm_pkg::MAX_FRAMES];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < frsm_pkg::MAX_FRAMES; k++) begin
                r_status[k] <= frsm_pkg::FS_FREE;
            end
        end else if (i_wr.en) begin
            r_status[i_wr.addr] <= i_wr.data;
        end
    end

    assign o_rd_data = r_status[i_rd_addr];

endmodule

### rtl/frame_ring_status_manager_core.sv
// Top level of the frame ring status manager: request sequencer and result register.
`timescale 1ns / 1ps
`include "frame_ring_status_manager_core_defines.svh"

// A request is taken when start is high and busy is low; its single result
// appears on the o_ ports for one cycle with o_valid, and the receiver cannot
// stall it. Produce and get requests walk the ring one frame per cycle through
// a single compare-and-advance step, holding busy while they examine 1 up to
// the ring size (at most 8) frames, and the result shows the cycle after the
// last one; a put or an unknown request passes through one check state. A new
// request may be started in the same cycle that the previous result is shown.
// The frame_count register may be written only while busy is low.
module frame_ring_status_manager_core (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_wr_en,
    input  logic [frsm_pkg::COUNT_W-1:0]    i_frame_count,
    input  logic                            start,
    output logic                            busy,
    input  logic [frsm_pkg::REQ_W-1:0]      i_req_type,
    input  logic [frsm_pkg::FRAME_W-1:0]    i_frame_index,
    output logic                            o_valid,
    output logic                            o_ok,
    output logic [frsm_pkg::FRAME_W-1:0]    o_chosen_frame,
    output logic [frsm_pkg::CODE_W-1:0]     o_status_code
);

    frsm_pkg::t_state r_state, n_state;

    logic [frsm_pkg::COUNT_W-1:0]  r_frame_count;
    logic [frsm_pkg::REQ_W-1:0]    r_req, n_req;
    logic [frsm_pkg::COUNT_W-1:0]  r_ring_n, n_ring_n;
    logic [frsm_pkg::FRAME_W-1:0]  r_scan, n_scan;
    logic [frsm_pkg::COUNT_W-1:0]  r_steps, n_steps;
    logic [frsm_pkg::FRAME_W-1:0]  r_prod_ptr, n_prod_ptr;
    logic [frsm_pkg::FRAME_W-1:0]  r_cons_ptr, n_cons_ptr;
    logic                          r_valid, n_valid;
    logic                          r_ok, n_ok;
    logic [frsm_pkg::FRAME_W-1:0]  r_frame, n_frame;
    logic [frsm_pkg::CODE_W-1:0]   r_code, n_code;

    logic [frsm_pkg::STATUS_W-1:0] rd_status;
    logic [frsm_pkg::STATUS_W-1:0] want;
    logic [frsm_pkg::COUNT_W-1:0]  acc_n;
    logic [frsm_pkg::FRAME_W-1:0]  acc_ptr;
    logic [frsm_pkg::COUNT_W-1:0]  scan_next;
    frsm_pkg::t_tbl_wr             tbl_wr;

    frsm_status_table u_table (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_addr (r_scan),
        .o_rd_data (rd_status),
        .i_wr      (tbl_wr)
    );

    assign acc_n     = frsm_pkg::ring_size(r_frame_count);
    assign scan_next = frsm_pkg::ring_next({1'b0, r_scan}, r_ring_n);
    assign want      = (r_req == frsm_pkg::REQ_PRODUCE) ? frsm_pkg::FS_FREE
                                                        : frsm_pkg::FS_READY;

    always_comb begin
        acc_ptr = (i_req_type == frsm_pkg::REQ_PRODUCE) ? r_prod_ptr : r_cons_ptr;
        // A pointer left outside a shrunken ring restarts the scan at frame 0.
        if ({1'b0, acc_ptr} >= acc_n) begin
            acc_ptr = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= frsm_pkg::ST_IDLE;
            r_frame_count <= frsm_pkg::FRAME_COUNT_RESET;
            r_prod_ptr    <= '0;
            r_cons_ptr    <= '0;
            r_valid       <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_prod_ptr <= n_prod_ptr;
            r_cons_ptr <= n_cons_ptr;
            r_valid    <= n_valid;
            if (i_cfg_wr_en) begin
                r_frame_count <= i_frame_count;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_req    <= n_req;
        r_ring_n <= n_ring_n;
        r_scan   <= n_scan;
        r_steps  <= n_steps;
        r_ok     <= n_ok;
        r_frame  <= n_frame;
        r_code   <= n_code;
    end

    always_comb begin
        n_state    = r_state;
        n_req      = r_req;
        n_ring_n   = r_ring_n;
        n_scan     = r_scan;
        n_steps    = r_steps;
        n_prod_ptr = r_prod_ptr;
        n_cons_ptr = r_cons_ptr;
        n_valid    = 1'b0;
        n_ok       = r_ok;
        n_frame    = r_frame;
        n_code     = r_code;
        tbl_wr     = '0;

        case (r_state)
            frsm_pkg::ST_IDLE: begin
                if (start) begin
                    n_req    = i_req_type;
                    n_ring_n = acc_n;
                    n_steps  = '0;
                    if (i_req_type == frsm_pkg::REQ_PRODUCE ||
                        i_req_type == frsm_pkg::REQ_GET) begin
                        n_scan  = acc_ptr;
                        n_state = frsm_pkg::ST_SCAN;
                    end else begin
                        n_scan  = i_frame_index;
                        n_state = frsm_pkg::ST_CHECK;
                    end
                end
            end
            frsm_pkg::ST_SCAN: begin
                if (rd_status == want) begin
                    tbl_wr.en   = 1'b1;
                    tbl_wr.addr = r_scan;
                    tbl_wr.data = (r_req == frsm_pkg::REQ_PRODUCE) ? frsm_pkg::FS_READY
                                                                   : frsm_pkg::FS_INUSE;
                    if (r_req == frsm_pkg::REQ_PRODUCE) begin
                        n_prod_ptr = scan_next[frsm_pkg::FRAME_W-1:0];
                    end else begin
                        n_cons_ptr = scan_next[frsm_pkg::FRAME_W-1:0];
                    end
                    n_valid = 1'b1;
                    n_ok    = 1'b1;
                    n_frame = r_scan;
                    n_code  = frsm_pkg::CODE_OK;
                    n_state = frsm_pkg::ST_IDLE;
                end else if (r_steps == r_ring_n - 4'd1) begin
                    n_valid = 1'b1;
                    n_ok    = 1'b0;
                    n_frame = '0;
                    n_code  = (r_req == frsm_pkg::REQ_PRODUCE) ? frsm_pkg::CODE_NO_FREE
                                                               : frsm_pkg::CODE_NO_READY;
                    n_state = frsm_pkg::ST_IDLE;
                end else begin
                    n_scan  = scan_next[frsm_pkg::FRAME_W-1:0];
                    n_steps = r_steps + 4'd1;
                end
            end
            frsm_pkg::ST_CHECK: begin
                n_valid = 1'b1;
                n_state = frsm_pkg::ST_IDLE;
                if (r_req == frsm_pkg::REQ_PUT && {1'b0, r_scan} < r_ring_n &&
                    rd_status == frsm_pkg::FS_INUSE) begin
                    tbl_wr.en   = 1'b1;
                    tbl_wr.addr = r_scan;
                    tbl_wr.data = frsm_pkg::FS_FREE;
                    n_ok        = 1'b1;
                    n_frame     = r_scan;
                    n_code      = frsm_pkg::CODE_OK;
                end else begin
                    n_ok    = 1'b0;
                    n_frame = '0;
                    n_code  = frsm_pkg::CODE_BAD_PUT;
                end
            end
            default: begin
                n_state = frsm_pkg::ST_IDLE;
            end
        endcase
    end

    assign busy           = (r_state != frsm_pkg::ST_IDLE);
    assign o_valid        = r_valid;
    assign o_ok           = r_ok;
    assign o_chosen_frame = r_frame;
    assign o_status_code  = r_code;

    `FRSM_ASSERT_NXT(a_accept_busy, i_clk, i_rst_n, start && !busy, busy, "accepted item did not raise busy")
    `FRSM_ASSERT_IMP(a_result_idle, i_clk, i_rst_n, o_valid, !busy, "result shown while still busy")
    `FRSM_ASSERT_IMP(a_ok_code, i_clk, i_rst_n, o_valid && o_ok, o_status_code == frsm_pkg::CODE_OK, "success with error code")
    `FRSM_ASSERT_IMP(a_fail_frame, i_clk, i_rst_n, o_valid && !o_ok, o_chosen_frame == '0 && o_status_code != frsm_pkg::CODE_OK, "bad failure result")
    `FRSM_ASSERT_IMP(a_scan_bound, i_clk, i_rst_n, r_state == frsm_pkg::ST_SCAN, r_steps < r_ring_n && {1'b0, r_scan} < r_ring_n, "scan ran past the ring")

endmodule

### tb/sv/frame_ring_status_manager_core_tb.sv
// Self-checking testbench for the frame ring status manager core.
`timescale 1ns / 1ps

module frame_ring_status_manager_core_tb;

    typedef logic [frsm_pkg::FRAME_W-1:0]  t_frame;
    typedef logic [frsm_pkg::COUNT_W-1:0]  t_count;
    typedef logic [frsm_pkg::REQ_W-1:0]    t_req;
    typedef logic [frsm_pkg::STATUS_W-1:0] t_status;

    // Request type with no meaning; the block must reject it.
    localparam t_req REQ_UNKNOWN = 2'd3;
    localparam int STALL_LIMIT = 1000;
    localparam int PHASE_ITEMS = 160;

    typedef struct packed {
        logic                          ok;
        logic [frsm_pkg::FRAME_W-1:0]  frame;
        logic [frsm_pkg::CODE_W-1:0]   code;
    } t_frame_result;

    logic                           i_clk = 1'b0;
    logic                           i_rst_n;
    logic                           i_cfg_wr_en;
    logic [frsm_pkg::COUNT_W-1:0]   i_frame_count;
    logic                           start;
    logic                           busy;
    logic [frsm_pkg::REQ_W-1:0]     i_req_type;
    logic [frsm_pkg::FRAME_W-1:0]   i_frame_index;
    logic                           o_valid;
    logic                           o_ok;
    logic [frsm_pkg::FRAME_W-1:0]   o_chosen_frame;
    logic [frsm_pkg::CODE_W-1:0]    o_status_code;

    // Shadow copy of the ring that tracks what the block should hold.
    logic [frsm_pkg::STATUS_W-1:0]  shadow_status [frsm_pkg::MAX_FRAMES];
    logic [frsm_pkg::FRAME_W-1:0]   shadow_prod_ptr;
    logic [frsm_pkg::FRAME_W-1:0]   shadow_cons_ptr;
    logic [frsm_pkg::COUNT_W-1:0]   shadow_frame_count;

    t_frame_result        pending_results[$];
    int                   err_count = 0;
    bit                   no_idle = 1'b0;

    frame_ring_status_manager_core dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_frame_count  (i_frame_count),
        .start          (start),
        .busy           (busy),
        .i_req_type     (i_req_type),
        .i_frame_index  (i_frame_index),
        .o_valid        (o_valid),
        .o_ok           (o_ok),
        .o_chosen_frame (o_chosen_frame),
        .o_status_code  (o_status_code)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic int active_ring_len();
        int n;
        n = int'(shadow_frame_count);
        if (n == 0) begin
            n = 1;
        end else if (n > frsm_pkg::MAX_FRAMES) begin
            n = frsm_pkg::MAX_FRAMES;
        end
        return n;
    endfunction

    function automatic int step_in_ring(int i, int n);
        return (i + 1 >= n) ? 0 : i + 1;
    endfunction

    // Returns n when no frame in the ring has the wanted status.
    function automatic int scan_ring(int from, t_status want, int n);
        int i;
        i = (from >= n) ? 0 : from;
        for (int k = 0; k < n; k++) begin
            if (shadow_status[i] == want) begin
                return i;
            end
            i = step_in_ring(i, n);
        end
        return n;
    endfunction

    function automatic t_frame_result apply_request(t_req req, t_frame idx);
        t_frame_result r;
        int n;
        int f;
        n = active_ring_len();
        r = '{1'b0, '0, frsm_pkg::CODE_BAD_PUT};
        case (req)
            frsm_pkg::REQ_PRODUCE: begin
                f = scan_ring(int'(shadow_prod_ptr), frsm_pkg::FS_FREE, n);
                if (f < n) begin
                    shadow_status[f] = frsm_pkg::FS_READY;
                    shadow_prod_ptr = t_frame'(step_in_ring(f, n));
                    r = '{1'b1, t_frame'(f), frsm_pkg::CODE_OK};
                end else begin
                    r.code = frsm_pkg::CODE_NO_FREE;
                end
            end
            frsm_pkg::REQ_GET: begin
                f = scan_ring(int'(shadow_cons_ptr), frsm_pkg::FS_READY, n);
                if (f < n) begin
                    shadow_status[f] = frsm_pkg::FS_INUSE;
                    shadow_cons_ptr = t_frame'(step_in_ring(f, n));
                    r = '{1'b1, t_frame'(f), frsm_pkg::CODE_OK};
                end else begin
                    r.code = frsm_pkg::CODE_NO_READY;
                end
            end
            frsm_pkg::REQ_PUT: begin
                if (int'(idx) < n && shadow_status[idx] == frsm_pkg::FS_INUSE) begin
                    shadow_status[idx] = frsm_pkg::FS_FREE;
                    r = '{1'b1, idx, frsm_pkg::CODE_OK};
                end
            end
            default: begin
            end
        endcase
        return r;
    endfunction

    // Picks a frame inside the ring that is currently handed out, if any.
    function automatic bit pick_inuse_frame(output t_frame f);
        int cands[$];
        int n;
        n = active_ring_len();
        for (int i = 0; i < n; i++) begin
            if (shadow_status[i] == frsm_pkg::FS_INUSE) begin
                cands.push_back(i);
            end
        end
        f = '0;
        if (cands.size() == 0) begin
            return 1'b0;
        end
        f = t_frame'(cands[$urandom_range(0, cands.size() - 1)]);
        return 1'b1;
    endfunction

    task automatic send_item(input t_req req, input t_frame idx);
        while (!no_idle && $urandom_range(0, 99) < 12) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start         <= 1'b1;
        i_req_type    <= req;
        i_frame_index <= idx;
        do @(posedge i_clk); while (busy);
        pending_results.push_back(apply_request(req, idx));
    endtask

    // Holds the sender off until every outstanding result has come back.
    task automatic wait_ring_quiet();
        start <= 1'b0;
        do @(posedge i_clk); while (pending_results.size() != 0 || busy);
        @(posedge i_clk);
    endtask

    task automatic write_frame_count(input t_count value);
        i_cfg_wr_en   <= 1'b1;
        i_frame_count <= value;
        @(posedge i_clk);
        shadow_frame_count = value;
        i_cfg_wr_en <= 1'b0;
    endtask

    task automatic test_basic_ops();
        send_item(frsm_pkg::REQ_GET, 3'd0);
        send_item(frsm_pkg::REQ_PUT, 3'd0);
        send_item(REQ_UNKNOWN, 3'd7);
        repeat (4) send_item(frsm_pkg::REQ_PRODUCE, 3'd5);
        repeat (2) send_item(frsm_pkg::REQ_GET, 3'd2);
        send_item(frsm_pkg::REQ_PUT, 3'd1);
        // Frame 2 is ready, not handed out, so the put must be refused.
        send_item(frsm_pkg::REQ_PUT, 3'd2);
        send_item(frsm_pkg::REQ_PUT, 3'd7);
        wait_ring_quiet();
    endtask

    task automatic test_ring_resize();
        write_frame_count(4'd8);
        repeat (2) send_item(frsm_pkg::REQ_PRODUCE, 3'd0);
        send_item(frsm_pkg::REQ_GET, 3'd0);
        wait_ring_quiet();
        // The producer pointer now sits past the shrunken ring.
        write_frame_count(4'd2);
        send_item(frsm_pkg::REQ_PRODUCE, 3'd0);
        send_item(frsm_pkg::REQ_PUT, 3'd3);
        wait_ring_quiet();
        write_frame_count(4'd0);
        send_item(frsm_pkg::REQ_PRODUCE, 3'd0);
        send_item(frsm_pkg::REQ_GET, 3'd0);
        send_item(frsm_pkg::REQ_PUT, 3'd0);
        wait_ring_quiet();
        write_frame_count(4'd15);
        send_item(frsm_pkg::REQ_PRODUCE, 3'd6);
        send_item(frsm_pkg::REQ_GET, 3'd1);
        wait_ring_quiet();
    endtask

    task automatic test_random_traffic();
        t_count counts [12];
        t_frame idx;
        t_req   req;
        int     sel;
        counts = '{4'd1, 4'd8, 4'd0, 4'd15, 4'd5, 4'd2, 4'd9, 4'd7, 4'd4, 4'd3, 4'd6, 4'd0};
        counts[11] = t_count'($urandom_range(0, 15));
        for (int p = 0; p < 12; p++) begin
            write_frame_count(counts[p]);
            no_idle = (p == 1);
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                sel = $urandom_range(0, 99);
                idx = t_frame'($urandom_range(0, frsm_pkg::MAX_FRAMES - 1));
                if (sel < 35) begin
                    req = frsm_pkg::REQ_PRODUCE;
                end else if (sel < 65) begin
                    req = frsm_pkg::REQ_GET;
                end else if (sel < 95) begin
                    req = frsm_pkg::REQ_PUT;
                    // Mostly hand back a frame that is really out, else a random one.
                    if ($urandom_range(0, 99) < 80) begin
                        if (!pick_inuse_frame(idx)) begin
                            idx = t_frame'($urandom_range(0, frsm_pkg::MAX_FRAMES - 1));
                        end
                    end
                end else begin
                    req = REQ_UNKNOWN;
                end
                send_item(req, idx);
                if ($urandom_range(0, 49) == 0) begin
                    wait_ring_quiet();
                end
            end
            no_idle = 1'b0;
            wait_ring_quiet();
        end
    endtask

    always @(posedge i_clk) begin
        t_frame_result exp;
        if (i_rst_n && o_valid) begin
            if (pending_results.size() == 0) begin
                $error("unexpected result: ok %0d frame %0d code %0d",
                       o_ok, o_chosen_frame, o_status_code);
                err_count++;
            end else begin
                exp = pending_results.pop_front();
                if (o_ok !== exp.ok) begin
                    $error("ok: expected %0d, actual %0d", exp.ok, o_ok);
                    err_count++;
                end
                if (o_chosen_frame !== exp.frame) begin
                    $error("chosen_frame: expected %0d, actual %0d", exp.frame, o_chosen_frame);
                    err_count++;
                end
                if (o_status_code !== exp.code) begin
                    $error("status_code: expected %0d, actual %0d", exp.code, o_status_code);
                    err_count++;
                end
            end
        end
    end

    initial begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((start && !busy) || o_valid) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
        $display("** frame_ring_status_manager_core: FAILED **");
        $finish;
    end

    initial begin
        i_rst_n       <= 1'b0;
        i_cfg_wr_en   <= 1'b0;
        i_frame_count <= frsm_pkg::FRAME_COUNT_RESET;
        start         <= 1'b0;
        i_req_type    <= frsm_pkg::REQ_PRODUCE;
        i_frame_index <= '0;
        for (int i = 0; i < frsm_pkg::MAX_FRAMES; i++) begin
            shadow_status[i] = frsm_pkg::FS_FREE;
        end
        shadow_prod_ptr    = '0;
        shadow_cons_ptr    = '0;
        shadow_frame_count = frsm_pkg::FRAME_COUNT_RESET;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_basic_ops();
        test_ring_resize();
        test_random_traffic();

        wait_ring_quiet();
        repeat (16) @(posedge i_clk);
        if (pending_results.size() != 0) begin
            $error("%0d results never arrived", pending_results.size());
            err_count++;
        end
        if (err_count == 0) begin
            $display("** frame_ring_status_manager_core: PASSED **");
        end else begin
            $display("** frame_ring_status_manager_core: FAILED **");
        end
        $finish;
    end

endmodule
